// File: rtl/core/smr_pkg.sv
// smr_pkg: shared widths, register indexes and types of the sample maxval rescaler
// used by smr_divider and sample_maxval_rescaler; depends on nothing
`default_nettype none

package smr_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int CFG_IDX_W = 1;

    // at or below this a maximum selects 8-bit samples
    localparam logic [SAMPLE_W-1:0] EIGHT_BIT_LIMIT = 16'd255;

    // divider: quotient bits resolved per pipeline stage
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = PROD_W / DIV_BITS_PER_STAGE;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_MAXVAL = 1'b0,
        CFG_TARGET_MAXVAL = 1'b1
    } t_cfg_idx;

    // per-item flags that ride alongside the division
    typedef struct packed {
        logic over;
        logic dst8;
        logic src_zero;
    } t_side;

endpackage

`default_nettype wire

// File: rtl/core/sample_maxval_rescaler.sv
// sample_maxval_rescaler: top level, rescales one sample per transfer by target/source maxval
// depends on smr_pkg and smr_divider
//
// channel  dir     handshake                  payload
// s        slave   i_s_tvalid / o_s_tready    i_s_tdata[15:0] sample_in
// m        master  o_m_tvalid / i_m_tready    o_m_tdata[15:0] sample_out, o_m_tuser[0] over_range
// cfg      write   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one sample per cycle sustained while the output is not stalled; the path runs through the
// input stage, the 16x16 multiply stage, the divider pipeline and the output register
// every stage has its own valid bit and loads when it is empty or its successor moves,
// so a stall on the output only fills the pipeline and bubbles close up
// reset is synchronous; it empties the pipeline and sets both maxima to 255
`default_nettype none

module sample_maxval_rescaler (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [15:0]                         i_s_tdata,  // [15:0] sample_in
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [15:0]                              o_m_tdata,  // [15:0] sample_out
    output logic [0:0]                               o_m_tuser,  // [0] over_range
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [smr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [smr_pkg::SAMPLE_W-1:0]        i_cfg_data
);
    import smr_pkg::*;

    logic [SAMPLE_W-1:0] r_source_maxval;
    logic [SAMPLE_W-1:0] r_target_maxval;

    // input stage
    logic                r_a_valid;
    logic [SAMPLE_W-1:0] r_a_sample;
    logic                a_rdy;

    // product stage
    logic                r_b_valid;
    logic [PROD_W-1:0]   r_b_prod;
    t_side               r_b_side;
    logic                b_rdy;

    // divider and output stage
    logic                div_in_rdy;
    logic                div_valid;
    logic [PROD_W-1:0]   div_quo;
    t_side               div_side;
    logic                out_rdy;
    logic                r_o_valid;
    logic [SAMPLE_W-1:0] r_o_sample;
    logic                r_o_over;
    logic [SAMPLE_W-1:0] n_o_sample;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_maxval <= EIGHT_BIT_LIMIT;
            r_target_maxval <= EIGHT_BIT_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SOURCE_MAXVAL: r_source_maxval <= i_cfg_data;
                CFG_TARGET_MAXVAL: r_target_maxval <= i_cfg_data;
            endcase
        end
    end

    // ready chain, output side first
    assign out_rdy    = !r_o_valid || i_m_tready;
    assign b_rdy      = !r_b_valid || div_in_rdy;
    assign a_rdy      = !r_a_valid || b_rdy;
    assign o_s_tready = a_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_rdy)   r_a_valid <= i_s_tvalid;
            if (b_rdy)   r_b_valid <= r_a_valid;
            if (out_rdy) r_o_valid <= div_valid;
        end
    end

    // 8-bit source mode keeps only the low byte
    always_ff @(posedge i_clk) begin
        if (a_rdy && i_s_tvalid) begin
            if (r_source_maxval <= EIGHT_BIT_LIMIT) begin
                r_a_sample <= {8'd0, i_s_tdata[7:0]};
            end else begin
                r_a_sample <= i_s_tdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_rdy && r_a_valid) begin
            r_b_prod          <= PROD_W'(r_a_sample) * PROD_W'(r_target_maxval);
            r_b_side.over     <= (r_a_sample > r_source_maxval);
            r_b_side.dst8     <= (r_target_maxval <= EIGHT_BIT_LIMIT);
            r_b_side.src_zero <= (r_source_maxval == '0);
        end
    end

    smr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_b_valid),
        .o_ready    (div_in_rdy),
        .i_dividend (r_b_prod),
        .i_divisor  (r_source_maxval),
        .i_side     (r_b_side),
        .o_valid    (div_valid),
        .i_ready    (out_rdy),
        .o_quotient (div_quo),
        .o_side     (div_side)
    );

    // zero source maximum gives zero, otherwise wrap to the target width
    always_comb begin
        if (div_side.src_zero) begin
            n_o_sample = '0;
        end else if (div_side.dst8) begin
            n_o_sample = {8'd0, div_quo[7:0]};
        end else begin
            n_o_sample = div_quo[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && div_valid) begin
            r_o_sample <= n_o_sample;
            r_o_over   <= div_side.over;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_sample;
    assign o_m_tuser  = r_o_over;

endmodule

`default_nettype wire

// File: rtl/core/smr_divider.sv
// smr_divider: pipelined restoring divider, 32-bit dividend by 16-bit divisor
// several quotient bits per stage, per-stage valid and ready; uses smr_pkg
`default_nettype none

module smr_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [smr_pkg::PROD_W-1:0]    i_dividend,
    input  wire logic [smr_pkg::SAMPLE_W-1:0]  i_divisor,
    input  wire smr_pkg::t_side                i_side,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [smr_pkg::PROD_W-1:0]         o_quotient,
    output smr_pkg::t_side                     o_side
);
    import smr_pkg::*;

    // partial remainder and the shifting dividend / quotient word
    typedef struct packed {
        logic [SAMPLE_W-1:0] rem;
        logic [PROD_W-1:0]   quo;
    } t_div;

    function automatic t_div div_step(t_div s, logic [SAMPLE_W-1:0] d);
        logic [SAMPLE_W:0] t;
        logic [SAMPLE_W:0] diff;
        logic              ge;
        t_div              r;
        t    = {s.rem, s.quo[PROD_W-1]};
        diff = t - {1'b0, d};
        ge   = (t >= {1'b0, d});
        r.quo = {s.quo[PROD_W-2:0], ge};
        r.rem = ge ? diff[SAMPLE_W-1:0] : t[SAMPLE_W-1:0];
        return r;
    endfunction

    logic  s_valid [DIV_STAGES];
    logic  s_rdy   [DIV_STAGES];
    t_div  s_st    [DIV_STAGES];
    t_side s_side  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic  r_valid;
        t_div  r_st;
        t_side r_side;
        t_div  n_st;
        logic  in_valid;
        t_div  in_st;
        t_side in_side;
        logic  down_rdy;

        if (k == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_st    = '{rem: '0, quo: i_dividend};
            assign in_side  = i_side;
        end else begin : g_next
            assign in_valid = s_valid[k-1];
            assign in_st    = s_st[k-1];
            assign in_side  = s_side[k-1];
        end

        if (k == DIV_STAGES - 1) begin : g_last
            assign down_rdy = i_ready;
        end else begin : g_mid
            assign down_rdy = s_rdy[k+1];
        end

        always_comb begin
            n_st = in_st;
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
                n_st = div_step(n_st, i_divisor);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (s_rdy[k]) begin
                r_valid <= in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (s_rdy[k] && in_valid) begin
                r_st   <= n_st;
                r_side <= in_side;
            end
        end

        assign s_rdy[k]   = !r_valid || down_rdy;
        assign s_valid[k] = r_valid;
        assign s_st[k]    = r_st;
        assign s_side[k]  = r_side;
    end

    assign o_ready    = s_rdy[0];
    assign o_valid    = s_valid[DIV_STAGES-1];
    assign o_quotient = s_st[DIV_STAGES-1].quo;
    assign o_side     = s_side[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/core/smr_checker.sv
// smr_checker: port-level assertions for sample_maxval_rescaler, bound to the top level
// watches the stream handshakes and the result payload; depends on nothing else
`default_nettype none

module smr_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                o_s_tready,
    input  wire logic                                o_m_tvalid,
    input  wire logic                                i_m_tready,
    input  wire logic [15:0]                         o_m_tdata,
    input  wire logic [0:0]                          o_m_tuser
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // a stalled result holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled output transfer changed");

    // with the output free to move, the whole pipeline moves and the input is open
    a_input_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input blocked while output side can move");

endmodule

bind sample_maxval_rescaler smr_checker u_smr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);

`default_nettype wire
